// ===== rtl/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, types and codes for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;
	localparam int MaxSegments = 32;
	localparam int AddrWidth   = 24;
	localparam int IdxWidth    = $clog2(MaxSegments);
	localparam int CntWidth    = $clog2(MaxSegments + 1);
	localparam int PidWidth    = 16;
	localparam int TotWidth    = 32;
	localparam int CfgWidth    = 24;
	localparam logic [AddrWidth-1:0] ResetMemory = AddrWidth'(65536);

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_mode_t;

	typedef enum logic [0:0] {
		REG_FIT_MODE     = 1'd0,
		REG_TOTAL_MEMORY = 1'd1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_FREED     = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_FIT    = 3'd3,
		ST_FULL      = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic [PidWidth-1:0]  owner;
		logic [AddrWidth-1:0] base;
		logic [AddrWidth-1:0] length;
		logic                 used;
	} seg_t;

	typedef struct packed {
		logic                 we;
		logic [IdxWidth-1:0]  waddr;
		seg_t                 wdata;
		logic [IdxWidth-1:0]  raddr;
	} mem_req_t;

	function automatic logic [TotWidth-1:0] sat_add(input logic [TotWidth-1:0] a,
			input logic [TotWidth-1:0] b);
		logic [TotWidth:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[TotWidth] ? {TotWidth{1'b1}} : s[TotWidth-1:0];
	endfunction
endpackage

// ===== rtl/vpa_if.sv =====
// ----------------------------------------------------------------------------
// vpa_req_if / vpa_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface vpa_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] process_id;
	logic [23:0] request_size;
	modport source (output valid, action, process_id, request_size, input ready);
	modport sink (input valid, action, process_id, request_size, output ready);
endinterface

interface vpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [23:0] seg_start;
	logic [23:0] seg_size;
	logic [31:0] created_total;
	logic [31:0] allocated_total;
	logic [31:0] terminated_total;
	logic [31:0] freed_total;
	modport source (output valid, status, seg_start, seg_size, created_total,
		allocated_total, terminated_total, freed_total, input ready);
	modport sink (input valid, status, seg_start, seg_size, created_total,
		allocated_total, terminated_total, freed_total, output ready);
endinterface

// ===== rtl/vpa_seg_ram.sv =====
// ----------------------------------------------------------------------------
// vpa_seg_ram
// Segment table storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vpa_seg_ram import vpa_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output seg_t     rdata
);
	seg_t mem [MaxSegments];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

// ===== rtl/vpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: scans, shifts and merges entries of the segment table.
// ----------------------------------------------------------------------------
module vpa_ctrl import vpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CfgWidth-1:0]  cfg_wdata,
	vpa_req_if.sink              req,
	vpa_rsp_if.source            rsp,
	output mem_req_t             mreq,
	input  seg_t                 rdata
);
	typedef enum logic [9:0] {
		S_INIT   = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_SCAN   = 10'b0000000100,
		S_DECIDE = 10'b0000001000,
		S_SHIFT  = 10'b0000010000,
		S_SPLIT  = 10'b0000100000,
		S_FNEXT  = 10'b0001000000,
		S_FPREV  = 10'b0010000000,
		S_REMOVE = 10'b0100000000,
		S_RESP   = 10'b1000000000
	} state_t;

	state_t                state_q;
	logic [1:0]            fit_q;
	logic [AddrWidth-1:0]  total_q;
	logic [CntWidth-1:0]   count_q;
	logic [CntWidth-1:0]   scan_q;    // address being read
	logic [CntWidth-1:0]   chk_q;     // address of data now on rdata
	logic                  chk_v_q;
	logic                  found_q;
	logic [IdxWidth-1:0]   pick_q;
	seg_t                  pick_seg_q;
	logic                  action_q;
	logic [PidWidth-1:0]   pid_q;
	logic [AddrWidth-1:0]  size_q;
	logic [CntWidth-1:0]   ptr_q;     // shift/remove pointer
	logic [IdxWidth-1:0]   rm_q;      // entry being removed
	logic [AddrWidth-1:0]  merged_q;
	logic                  merge_prev_q;
	logic [IdxWidth-1:0]   cur_q;     // index of freed segment
	logic [2:0]            status_q;
	logic [AddrWidth-1:0]  start_q;
	logic [AddrWidth-1:0]  len_q;
	logic [TotWidth-1:0]   created_q, allocd_q, term_q, freed_q;
	logic                  rsp_valid_q;

	logic hit;
	logic better;
	logic prev_hole;

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.seg_start = start_q;
	assign rsp.seg_size = len_q;
	assign rsp.created_total = created_q;
	assign rsp.allocated_total = allocd_q;
	assign rsp.terminated_total = term_q;
	assign rsp.freed_total = freed_q;

	always_comb begin
		if (action_q) begin
			hit = rdata.used && rdata.owner == pid_q;
		end else begin
			hit = !rdata.used && rdata.length >= size_q;
		end
		better = 1'b0;
		if (fit_q == FIT_BEST) begin
			better = rdata.length < pick_seg_q.length;
		end else if (fit_q == FIT_WORST) begin
			better = rdata.length > pick_seg_q.length;
		end
		// entry before the freed segment is a hole
		prev_hole = cur_q != '0 && !rdata.used;
	end

	// read address follows the sequencer
	always_comb begin
		mreq = '0;
		mreq.raddr = scan_q[IdxWidth-1:0];
		unique case (state_q)
			S_INIT: begin
				mreq.we = 1'b1;
				mreq.waddr = '0;
				mreq.wdata = '{owner: '0, base: '0, length: total_q, used: 1'b0};
			end
			S_DECIDE: begin
				mreq.raddr = IdxWidth'(pick_q + 1'b1);
			end
			S_SHIFT: begin
				mreq.raddr = IdxWidth'(chk_v_q ? ptr_q - CntWidth'(2) : ptr_q - CntWidth'(1));
				mreq.we = chk_v_q;
				mreq.waddr = ptr_q[IdxWidth-1:0];
				mreq.wdata = rdata;
			end
			S_SPLIT: begin
				mreq.we = pick_seg_q.length != size_q;
				mreq.waddr = IdxWidth'(pick_q + 1'b1);
				mreq.wdata = '{owner: '0, base: pick_seg_q.base + size_q,
					length: pick_seg_q.length - size_q, used: 1'b0};
			end
			S_FNEXT: begin
				mreq.raddr = cur_q - 1'b1;
			end
			S_FPREV: begin
				mreq.raddr = IdxWidth'(ptr_q + 1'b1);
				mreq.we = 1'b1;
				mreq.waddr = prev_hole ? cur_q - 1'b1 : cur_q;
				mreq.wdata = '{owner: '0, base: prev_hole ? rdata.base : pick_seg_q.base,
					length: merged_q + (prev_hole ? rdata.length : '0), used: 1'b0};
			end
			S_REMOVE: begin
				mreq.raddr = IdxWidth'(chk_v_q ? ptr_q + 1'b1 : ptr_q);
				mreq.we = chk_v_q && ptr_q < count_q;
				mreq.waddr = IdxWidth'(ptr_q - CntWidth'(rm_q != '0)
					- CntWidth'(merge_prev_q));
				mreq.wdata = rdata;
			end
			S_RESP: begin
				mreq.we = status_q == ST_ALLOCATED;
				mreq.waddr = pick_q;
				mreq.wdata = '{owner: pid_q, base: pick_seg_q.base, length: size_q,
					used: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			fit_q <= FIT_FIRST;
			total_q <= ResetMemory;
			count_q <= CntWidth'(1);
			scan_q <= '0;
			chk_q <= '0;
			chk_v_q <= 1'b0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			created_q <= '0;
			allocd_q <= '0;
			term_q <= '0;
			freed_q <= '0;
			ptr_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == REG_FIT_MODE) begin
					fit_q <= cfg_wdata[1:0];
				end else begin
					total_q <= cfg_wdata;
					count_q <= CntWidth'(1);
					state_q <= S_INIT;
				end
			end
			unique case (state_q)
				S_INIT: begin
					if (!(cfg_we && cfg_index == REG_TOTAL_MEMORY)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						action_q <= req.action;
						pid_q <= req.process_id;
						size_q <= req.request_size;
						found_q <= 1'b0;
						scan_q <= '0;
						chk_v_q <= 1'b0;
						if (!req.action && (req.request_size > total_q
								|| req.request_size == '0)) begin
							status_q <= (req.request_size > total_q) ? ST_TOO_LARGE : ST_NO_FIT;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// one entry per cycle, data arrives in the cycle after its address
					chk_q <= scan_q;
					chk_v_q <= scan_q < count_q;
					if (scan_q < count_q) begin
						scan_q <= scan_q + 1'b1;
					end
					if (chk_v_q && hit && (!found_q || (!action_q && better))) begin
						found_q <= 1'b1;
						pick_q <= chk_q[IdxWidth-1:0];
						pick_seg_q <= rdata;
					end
					if (chk_v_q && hit && (action_q
							|| (fit_q != FIT_BEST && fit_q != FIT_WORST)) && !found_q) begin
						state_q <= S_DECIDE;
					end else if (!chk_v_q && scan_q >= count_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					chk_v_q <= 1'b0;
					if (!found_q) begin
						status_q <= action_q ? ST_NOT_FOUND : ST_NO_FIT;
						state_q <= S_RESP;
					end else if (action_q) begin
						cur_q <= pick_q;
						merged_q <= pick_seg_q.length;
						merge_prev_q <= 1'b0;
						status_q <= ST_FREED;
						start_q <= pick_seg_q.base;
						len_q <= pick_seg_q.length;
						scan_q <= CntWidth'(pick_q) + 1'b1;
						state_q <= S_FNEXT;
					end else if (pick_seg_q.length == size_q) begin
						status_q <= ST_ALLOCATED;
						state_q <= S_SPLIT;
					end else if (count_q >= CntWidth'(MaxSegments)) begin
						status_q <= ST_FULL;
						state_q <= S_RESP;
					end else begin
						status_q <= ST_ALLOCATED;
						ptr_q <= count_q;
						scan_q <= count_q - 1'b1;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// copy entry ptr-1 to ptr, descending to pick+2
					if (ptr_q <= CntWidth'(pick_q) + CntWidth'(1)) begin
						state_q <= S_SPLIT;
						chk_v_q <= 1'b0;
					end else if (!chk_v_q) begin
						chk_v_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q - 1'b1;
						chk_v_q <= ptr_q - 1'b1 > CntWidth'(pick_q) + CntWidth'(1);
					end
				end
				S_SPLIT: begin
					// the allocated segment itself is written at RESP via the port
					if (pick_seg_q.length != size_q) begin
						count_q <= count_q + 1'b1;
					end
					start_q <= pick_seg_q.base;
					len_q <= size_q;
					created_q <= sat_add(created_q, TotWidth'(1));
					allocd_q <= sat_add(allocd_q, TotWidth'(size_q));
					state_q <= S_RESP;
				end
				S_FNEXT: begin
					// rdata holds entry cur+1 (read issued in DECIDE)
					term_q <= sat_add(term_q, TotWidth'(1));
					freed_q <= sat_add(freed_q, TotWidth'(len_q));
					if (CntWidth'(cur_q) + 1'b1 < count_q && !rdata.used) begin
						merged_q <= merged_q + rdata.length;
						rm_q <= cur_q + 1'b1;
					end else begin
						rm_q <= '0;
					end
					state_q <= S_FPREV;
				end
				S_FPREV: begin
					// rdata holds entry cur-1 (read issued in FNEXT)
					merge_prev_q <= prev_hole;
					ptr_q <= CntWidth'(cur_q) + CntWidth'(1) + CntWidth'(rm_q != '0);
					chk_v_q <= 1'b0;
					state_q <= S_REMOVE;
					if (prev_hole) begin
						pick_seg_q.base <= rdata.base;
					end
				end
				S_REMOVE: begin
					// moves the entries above the merged hole down by one or two places
					if (ptr_q >= count_q || (rm_q == '0 && !merge_prev_q)) begin
						count_q <= count_q - CntWidth'(rm_q != '0) - CntWidth'(merge_prev_q);
						state_q <= S_RESP;
					end else if (!chk_v_q) begin
						chk_v_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_RESP: begin
					if (status_q != ST_ALLOCATED && status_q != ST_FREED) begin
						start_q <= '0;
						len_q <= '0;
					end
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/variable_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Segment table allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// One request at a time: a scan reads one table entry per cycle from the
// segment memory, then shifts or merges one entry per cycle. A new request
// is taken from the cycle after the result is taken. After reset and after
// a total_memory write the INIT state reinitialises the table.
module variable_partition_allocator import vpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CfgWidth-1:0] cfg_wdata,
	vpa_req_if.sink             req,
	vpa_rsp_if.source           rsp
);
	mem_req_t mreq;
	seg_t     rdata;

	vpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req), .rsp(rsp), .mreq(mreq), .rdata(rdata)
	);

	vpa_seg_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("accepted while result pending");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= ST_NOT_FOUND) else $error("bad status");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_ALLOCATED && rsp.status != ST_FREED)
		|-> (rsp.seg_start == '0 && rsp.seg_size == '0)) else $error("failure payload");
endmodule
